/* hdl/vt44_pkg.sv */
// Shared types and constants for the 4x4 vertex transform core.
`timescale 1ns / 1ps

package vt44_pkg;

	localparam int CoordW  = 32;
	localparam int FracW   = 16;
	localparam int NumRegs = 8;
	localparam int CfgIdxW = 3;
	localparam int RegW    = 2 * CoordW;
	localparam int ProdW   = 2 * CoordW;
	localparam int PairW   = ProdW + 1;
	localparam int SumW    = ProdW + 2;
	// Top of the range that still fits 32 bits after the shift by FracW.
	localparam int SatBit  = CoordW + FracW - 1;

	localparam logic signed [SumW-1:0] RoundBias = SumW'(1) <<< (FracW - 1);
	localparam logic signed [CoordW-1:0] SatMax = {1'b0, {(CoordW-1){1'b1}}};
	localparam logic signed [CoordW-1:0] SatMin = {1'b1, {(CoordW-1){1'b0}}};

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic [RegW-1:0] mat_reg_t;

	// Identity matrix, two Q16.16 elements per register, low element first.
	localparam mat_reg_t RegResetVals [NumRegs] = '{
		64'h0000_0000_0001_0000, 64'h0,
		64'h0001_0000_0000_0000, 64'h0,
		64'h0,                   64'h0000_0000_0001_0000,
		64'h0,                   64'h0001_0000_0000_0000
	};

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

/* hdl/vt44_col.sv */
// One result column: four products, pairwise sums, then rounding and saturation.
`timescale 1ns / 1ps

module vt44_col (
	input  logic                       clk,
	input  vt44_pkg::stage_en_t        en,
	input  vt44_pkg::coord_t [3:0]     vec_s1,
	input  vt44_pkg::coord_t [3:0]     mcol,
	output vt44_pkg::coord_t           res,
	output logic                       ovf
);

	logic signed [vt44_pkg::ProdW-1:0] prod_s2 [4];
	logic signed [vt44_pkg::PairW-1:0] pair_s3 [2];
	logic signed [vt44_pkg::SumW-1:0]  sum;
	logic                              sat_hi;
	logic                              sat_lo;
	vt44_pkg::coord_t                  res_s4;
	logic                              ovf_s4;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int i = 0; i < 4; i++) begin
				prod_s2[i] <= vt44_pkg::ProdW'(vec_s1[i]) * vt44_pkg::ProdW'(mcol[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			pair_s3[0] <= vt44_pkg::PairW'(prod_s2[0]) + vt44_pkg::PairW'(prod_s2[1]);
			pair_s3[1] <= vt44_pkg::PairW'(prod_s2[2]) + vt44_pkg::PairW'(prod_s2[3]);
		end
	end

	assign sum = vt44_pkg::SumW'(pair_s3[0]) + vt44_pkg::SumW'(pair_s3[1])
		+ vt44_pkg::RoundBias;

	// From 2^47 upward the shifted value no longer fits; the same holds below -2^47.
	assign sat_hi = !sum[vt44_pkg::SumW-1] && (|sum[vt44_pkg::SumW-2:vt44_pkg::SatBit]);
	assign sat_lo = sum[vt44_pkg::SumW-1] && !(&sum[vt44_pkg::SumW-2:vt44_pkg::SatBit]);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			if (sat_hi) begin
				res_s4 <= vt44_pkg::SatMax;
			end else if (sat_lo) begin
				res_s4 <= vt44_pkg::SatMin;
			end else begin
				res_s4 <= sum[vt44_pkg::SatBit:vt44_pkg::FracW];
			end
			ovf_s4 <= sat_hi || sat_lo;
		end
	end

	assign res = res_s4;
	assign ovf = ovf_s4;

endmodule

/* hdl/vertex_transform_4x4_core.sv */
// Top level of the 4x4 homogeneous vertex transform core.
`timescale 1ns / 1ps

// Multiplies each vector (x, y, z, w), as a row vector, by a 4x4 matrix of
// signed Q16.16 elements. Each result column is rounded to nearest and
// saturated to 32 bits; m_axis_tuser flags a saturated word.
// Channels: s_axis takes one vector per word, m_axis gives one result per word.
// The cfg channel writes one 64-bit matrix register per word (two elements,
// low element in the low half); it is always ready and should only be used
// while no vectors are in flight.
// Pipeline: the accepting edge loads the input register, and the product,
// pair-sum and result registers follow in that order, the last of them
// driving m_axis_tvalid. Sixteen parallel multipliers set the throughput
// of one word per cycle, as long as the receiver does not stall.
// Reset clears all valid bits and loads the identity matrix.
// When the receiver stalls, the result register holds its word and the
// stages behind it keep filling until every stage is occupied; empty stages
// are squeezed out, so s_axis_tready stays high while any bubble remains.
module vertex_transform_4x4_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [127:0]                  s_axis_tdata,  // vec_x, vec_y, vec_z, vec_w
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [127:0]                  m_axis_tdata,  // res_x, res_y, res_z, res_w
	output logic [0:0]                    m_axis_tuser,  // overflow
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [vt44_pkg::CfgIdxW-1:0]  cfg_index,
	input  vt44_pkg::mat_reg_t            cfg_data
);

	vt44_pkg::mat_reg_t        mat_q [vt44_pkg::NumRegs];
	vt44_pkg::coord_t [3:0]    vec_s1;
	vt44_pkg::coord_t [3:0]    res;
	logic [3:0]                ovf;
	logic                      vld_s1;
	logic                      vld_s2;
	logic                      vld_s3;
	logic                      vld_s4;
	logic                      en_s1;
	logic                      en_s2;
	logic                      en_s3;
	logic                      en_s4;
	vt44_pkg::stage_en_t       en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < vt44_pkg::NumRegs; k++) begin
				mat_q[k] <= vt44_pkg::RegResetVals[k];
			end
		end else if (cfg_valid) begin
			mat_q[cfg_index] <= cfg_data;
		end
	end

	// A stage loads when it is empty or its word moves on in the same cycle.
	assign en_s4  = !vld_s4 || m_axis_tready;
	assign en_s3  = !vld_s3 || en_s4;
	assign en_s2  = !vld_s2 || en_s3;
	assign en_s1  = !vld_s1 || en_s2;
	assign en     = '{s2: en_s2, s3: en_s3, s4: en_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
			if (en_s3) begin
				vld_s3 <= vld_s2;
			end
			if (en_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_axis_tvalid) begin
			vec_s1 <= s_axis_tdata;
		end
	end

	for (genvar j = 0; j < 4; j++) begin : g_col
		vt44_pkg::coord_t [3:0] mcol;

		for (genvar i = 0; i < 4; i++) begin : g_elem
			assign mcol[i] = mat_q[2 * i + j / 2][(j % 2) * vt44_pkg::CoordW +: vt44_pkg::CoordW];
		end

		vt44_col u_col (
			.clk    (clk),
			.en     (en),
			.vec_s1 (vec_s1),
			.mcol   (mcol),
			.res    (res[j]),
			.ovf    (ovf[j])
		);
	end

	assign s_axis_tready = en_s1;
	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = res;
	assign m_axis_tuser  = |ovf;

endmodule

/* hdl/vt44_checker.sv */
// Port-level checks for the vertex transform core, bound to its top level.
`timescale 1ns / 1ps

module vt44_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata,
	input logic [0:0]   m_axis_tuser
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// Overflow only comes with at least one saturated component.
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000 ||
			m_axis_tdata[63:32] == 32'h7FFF_FFFF || m_axis_tdata[63:32] == 32'h8000_0000 ||
			m_axis_tdata[95:64] == 32'h7FFF_FFFF || m_axis_tdata[95:64] == 32'h8000_0000 ||
			m_axis_tdata[127:96] == 32'h7FFF_FFFF || m_axis_tdata[127:96] == 32'h8000_0000)
		else $error("overflow flagged without a saturated component");

	// With no backpressure an accepted word reaches the output after the product, pair-sum and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready
			##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("result word missing after pipeline latency");

	// An empty output stage means the pipeline has room for a new word.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output stage is empty");

endmodule

bind vertex_transform_4x4_core vt44_checker u_vt44_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
